/* sv/crsi_pkg.sv */
// shared constants and types for the ray/circle slice intersection block
package crsi_pkg;

	// fraction bits of every coordinate and of the distance
	localparam int FRAC_BITS = 16;

	// multiplier operand bits consumed per pipeline stage
	localparam int MUL_DIGIT = 16;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_CENTER_Z = 2'd2,
		REG_RADIUS   = 2'd3
	} cfg_reg_t;

endpackage

/* sv/crsi_delay.sv */
// fixed-length register delay line with shared advance enable
module crsi_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_s [D];

	// shift one place whenever the pipeline advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) line_s[i] <= '0;
		end else if (en) begin
			line_s[0] <= d;
			for (int i = 1; i < D; i++) line_s[i] <= line_s[i-1];
		end
	end

	assign q = line_s[D-1];

endmodule

/* sv/crsi_front.sv */
// front end: offsets, squares and cross products, then a, h and c sums
module crsi_front #(
	parameter int N = 32
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [N-1:0] origin_x,
	input  logic signed [N-1:0] origin_y,
	input  logic signed [N-1:0] dir_x,
	input  logic signed [N-1:0] dir_y,
	input  logic signed [N-1:0] center_x,
	input  logic signed [N-1:0] center_y,
	input  logic signed [N-1:0] center_z,
	input  logic        [N-2:0] radius,
	output logic      [2*N-1:0] a,
	output logic signed [2*N+1:0] h,
	output logic signed [2*N+2:0] c
);

	localparam int WH = 2 * N + 2;
	localparam int WC = 2 * N + 3;

	logic signed [N:0]     px_s1, py_s1;
	logic signed [N-1:0]   dx_s1, dy_s1, cz_s1;
	logic        [N-2:0]   rr_s1;
	logic signed [2*N-1:0] dxx_s2, dyy_s2, czz_s2;
	logic signed [2*N:0]   dxpx_s2, dypy_s2;
	logic signed [2*N+1:0] pxx_s2, pyy_s2;
	logic        [2*N-3:0] rrr_s2;
	logic        [2*N-1:0] a_s3;
	logic signed [WH-1:0]  h_s3;
	logic signed [WC-1:0]  c_s3;

	// stage 1: origin relative to the centre, exact in one extra bit
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= $signed({origin_x[N-1], origin_x}) - $signed({center_x[N-1], center_x});
			py_s1 <= $signed({origin_y[N-1], origin_y}) - $signed({center_y[N-1], center_y});
			dx_s1 <= dir_x;
			dy_s1 <= dir_y;
			cz_s1 <= center_z;
			rr_s1 <= radius;
		end
	end

	// stage 2: all products
	always_ff @(posedge clk) begin
		if (en) begin
			dxx_s2  <= dx_s1 * dx_s1;
			dyy_s2  <= dy_s1 * dy_s1;
			dxpx_s2 <= dx_s1 * px_s1;
			dypy_s2 <= dy_s1 * py_s1;
			pxx_s2  <= px_s1 * px_s1;
			pyy_s2  <= py_s1 * py_s1;
			czz_s2  <= cz_s1 * cz_s1;
			rrr_s2  <= rr_s1 * rr_s1;
		end
	end

	// stage 3: quadratic coefficients, h being half of b
	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= $unsigned(dxx_s2) + $unsigned(dyy_s2);
			h_s3 <= WH'(dxpx_s2) + WH'(dypy_s2);
			c_s3 <= (WC'(pxx_s2) + WC'(pyy_s2)) + (WC'(czz_s2) - WC'($signed({1'b0, rrr_s2})));
		end
	end

	assign a = a_s3;
	assign h = h_s3;
	assign c = c_s3;

endmodule

/* sv/crsi_mul.sv */
// pipelined signed multiplier, one digit of the second operand per stage
module crsi_mul #(
	parameter int WA = 67,
	parameter int WB = 67
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic signed [WA+WB-1:0] p
);

	import crsi_pkg::*;

	localparam int NS  = (WB + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int WBX = NS * MUL_DIGIT;
	localparam int WR  = WA + WB;
	localparam int WT  = WA + MUL_DIGIT + 1;

	logic signed [WA-1:0]  a_in [NS];
	logic signed [WA-1:0]  a_s  [NS];
	logic signed [WBX-1:0] b_in [NS];
	logic signed [WBX-1:0] b_s  [NS];
	logic signed [WR-1:0]  acc_in [NS];
	logic signed [WR-1:0]  acc_s  [NS];
	logic signed [WT-1:0]  term [NS];

	// stage wiring and partial product per digit; the top digit carries the sign
	for (genvar k = 0; k < NS; k++) begin : g_digit
		logic [MUL_DIGIT-1:0] dig;
		if (k == 0) begin : g_first
			assign a_in[k]   = a;
			assign b_in[k]   = WBX'(b);
			assign acc_in[k] = '0;
		end else begin : g_next
			assign a_in[k]   = a_s[k-1];
			assign b_in[k]   = b_s[k-1];
			assign acc_in[k] = acc_s[k-1];
		end
		assign dig = b_in[k][k*MUL_DIGIT +: MUL_DIGIT];
		if (k == NS - 1) begin : g_top
			assign term[k] = a_in[k] * $signed(dig);
		end else begin : g_low
			assign term[k] = a_in[k] * $signed({1'b0, dig});
		end
	end

	// accumulate shifted partial products stage by stage
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NS; k++) begin
				a_s[k]   <= a_in[k];
				b_s[k]   <= b_in[k];
				acc_s[k] <= acc_in[k] + (WR'(term[k]) <<< (k * MUL_DIGIT));
			end
		end
	end

	assign p = acc_s[NS-1];

endmodule

/* sv/crsi_sqrt.sv */
// pipelined floor square root, one root bit per stage
module crsi_sqrt #(
	parameter int WI = 134
) (
	input  logic            clk,
	input  logic            en,
	input  logic [WI-1:0]   rad,
	output logic [WI/2-1:0] root
);

	localparam int RB = WI / 2;
	localparam int WR = RB + 3;

	logic [WI-1:0] rad_in  [RB];
	logic [WI-1:0] rad_s   [RB];
	logic [WR-1:0] rem_in  [RB];
	logic [WR-1:0] rem_s   [RB];
	logic [WR-1:0] rem_nx  [RB];
	logic [RB-1:0] root_in [RB];
	logic [RB-1:0] root_s  [RB];
	logic [RB-1:0] root_nx [RB];

	// trial subtract of 4*root+1 against the remainder with two new bits
	for (genvar k = 0; k < RB; k++) begin : g_bit
		logic [WR-1:0] shv, tv;
		logic          ge;
		if (k == 0) begin : g_first
			assign rad_in[k]  = rad;
			assign rem_in[k]  = '0;
			assign root_in[k] = '0;
		end else begin : g_next
			assign rad_in[k]  = rad_s[k-1];
			assign rem_in[k]  = rem_s[k-1];
			assign root_in[k] = root_s[k-1];
		end
		assign shv        = {rem_in[k][WR-3:0], rad_in[k][WI-1:WI-2]};
		assign tv         = WR'({root_in[k], 2'b01});
		assign ge         = (shv >= tv);
		assign rem_nx[k]  = ge ? (shv - tv) : shv;
		assign root_nx[k] = {root_in[k][RB-2:0], ge};
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < RB; k++) begin
				rad_s[k]  <= rad_in[k] << 2;
				rem_s[k]  <= rem_nx[k];
				root_s[k] <= root_nx[k];
			end
		end
	end

	assign root = root_s[RB-1];

endmodule

/* sv/crsi_div.sv */
// pipelined restoring divider with early overflow check, one quotient bit per stage
module crsi_div #(
	parameter int WN  = 85,
	parameter int WDV = 64,
	parameter int QB  = 33
) (
	input  logic           clk,
	input  logic           en,
	input  logic [WN-1:0]  num,
	input  logic [WDV-1:0] den,
	output logic [QB-1:0]  quo,
	output logic           rem_nz,
	output logic           ovf
);

	localparam int WHI = WN - QB;
	localparam int WM  = (WHI > WDV) ? WHI : WDV;

	logic           ovf_c;
	logic [WDV-1:0] rem0_s, den0_s;
	logic [QB-1:0]  low0_s;
	logic           ovf0_s;

	logic [WDV-1:0] rem_in [QB];
	logic [WDV-1:0] rem_s  [QB];
	logic [WDV-1:0] rem_nx [QB];
	logic [WDV-1:0] den_in [QB];
	logic [WDV-1:0] den_s  [QB];
	logic [QB-1:0]  low_in [QB];
	logic [QB-1:0]  low_s  [QB];
	logic [QB-1:0]  quo_in [QB];
	logic [QB-1:0]  quo_s  [QB];
	logic [QB-1:0]  quo_nx [QB];
	logic           ovf_in [QB];
	logic           ovf_s  [QB];

	// quotient too wide for QB bits when the high part already reaches the divisor
	assign ovf_c = (WM'(num[WN-1:QB]) >= WM'(den));

	// first stage: overflow check and initial remainder
	always_ff @(posedge clk) begin
		if (en) begin
			rem0_s <= ovf_c ? '0 : WDV'(num[WN-1:QB]);
			low0_s <= num[QB-1:0];
			den0_s <= den;
			ovf0_s <= ovf_c;
		end
	end

	// one shift, compare and subtract per stage
	for (genvar k = 0; k < QB; k++) begin : g_bit
		logic [WDV:0] shv;
		logic         ge;
		if (k == 0) begin : g_first
			assign rem_in[k] = rem0_s;
			assign den_in[k] = den0_s;
			assign low_in[k] = low0_s;
			assign quo_in[k] = '0;
			assign ovf_in[k] = ovf0_s;
		end else begin : g_next
			assign rem_in[k] = rem_s[k-1];
			assign den_in[k] = den_s[k-1];
			assign low_in[k] = low_s[k-1];
			assign quo_in[k] = quo_s[k-1];
			assign ovf_in[k] = ovf_s[k-1];
		end
		assign shv       = {rem_in[k], low_in[k][QB-1]};
		assign ge        = (shv >= {1'b0, den_in[k]});
		assign rem_nx[k] = ge ? WDV'(shv - {1'b0, den_in[k]}) : WDV'(shv);
		assign quo_nx[k] = {quo_in[k][QB-2:0], ge};
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QB; k++) begin
				rem_s[k] <= rem_nx[k];
				den_s[k] <= den_in[k];
				low_s[k] <= low_in[k] << 1;
				quo_s[k] <= quo_nx[k];
				ovf_s[k] <= ovf_in[k];
			end
		end
	end

	assign quo    = quo_s[QB-1];
	assign rem_nz = |rem_s[QB-1];
	assign ovf    = ovf_s[QB-1];

endmodule

/* sv/ray_circle_slice_intersect.sv */
// top level: ray/sphere intersection for rays in the z = 0 plane
//
// Usage:
//  - configuration: cfg_valid/cfg_ready write channel, cfg_index selects
//    center_x, center_y, center_z or sphere_radius, cfg_data carries the value;
//    cfg_ready is always high; writes are to be made while no item is in
//    flight, which the block itself does not enforce
//  - input items: origin_x/y and dir_x/y (signed Q16.16) taken on in_valid
//    with in_stall low
//  - result items: hit and distance (signed Q16.16, smaller root, saturated,
//    zero on a miss) offered on out_valid, taken when out_stall is low
//  - an item passes through the front end, the multipliers, the square root
//    stages (one root bit each) and the divider stages (one quotient bit each)
//  - throughput: one item per cycle while out_stall does not hold a result
//  - a held result freezes the whole pipeline and raises in_stall in the same
//    cycle; nothing is dropped or repeated
//  - reset clears all valid bits, the configuration registers and the delay
//    lines; the block accepts items as soon as reset is released
module ray_circle_slice_intersect #(
	parameter int COORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  crsi_pkg::cfg_reg_t           cfg_index,
	input  logic        [COORD_BITS-1:0] cfg_data,
	// input items
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] origin_x,
	input  logic signed [COORD_BITS-1:0] origin_y,
	input  logic signed [COORD_BITS-1:0] dir_x,
	input  logic signed [COORD_BITS-1:0] dir_y,
	// result items
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic signed [COORD_BITS-1:0] distance
);

	import crsi_pkg::*;

	localparam int N    = COORD_BITS;
	localparam int WA   = 2 * N;
	localparam int WH   = 2 * N + 2;
	localparam int WC   = 2 * N + 3;
	localparam int WD   = 2 * WC;
	localparam int RB   = WD / 2;
	localparam int WNUM = 2 * N + 5;
	localparam int WS   = WNUM + FRAC_BITS;
	localparam int QB   = N + 1;
	localparam int NS   = (WC + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int LAT  = 3 + NS + 1 + RB + 1 + (QB + 1) + 1;

	localparam logic [N+1:0] POS_LIM = ((N+2)'(1) << (N - 1)) - (N+2)'(1);
	localparam logic [N+1:0] NEG_LIM = (N+2)'(1) << (N - 1);
	localparam logic [N-1:0] MAX_VAL = {1'b0, {(N-1){1'b1}}};
	localparam logic [N-1:0] MIN_VAL = {1'b1, {(N-1){1'b0}}};

	logic signed [N-1:0] center_x_q, center_y_q, center_z_q;
	logic        [N-2:0] sphere_radius_q;

	logic                  en;
	logic                  vld_out;
	logic        [WA-1:0]  a3, a_m, a_r, a_dv;
	logic signed [WH-1:0]  h3, h_m, h_r;
	logic signed [WC-1:0]  c3;
	logic signed [WD-1:0]  hh_m, ac_m;
	logic signed [WD-1:0]  disc_c;
	logic        [RB-1:0]  root;
	logic                  hit_r, neg_d, hit_d;
	logic signed [WNUM-1:0] num_c;
	logic signed [WS-1:0]  shf_c;
	logic        [QB-1:0]  quo;
	logic                  rem_nz, ovf;
	logic        [N+1:0]   qm_c;
	logic        [N-1:0]   val_c;

	logic        [WD-1:0]  disc_s4;
	logic                  hit_s4;
	logic        [WA-1:0]  a_s4;
	logic signed [WH-1:0]  h_s4;
	logic        [WS-1:0]  mag_s5;
	logic                  neg_s5, hit_s5;
	logic        [WA-1:0]  a_s5;
	logic                  hit_s6;
	logic        [N-1:0]   dist_s6;

	// whole pipeline advances unless a finished item is held at the output
	assign en        = !(vld_out && out_stall);
	assign in_stall  = vld_out && out_stall;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q      <= '0;
			center_y_q      <= '0;
			center_z_q      <= '0;
			sphere_radius_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CENTER_X: center_x_q      <= cfg_data;
				REG_CENTER_Y: center_y_q      <= cfg_data;
				REG_CENTER_Z: center_z_q      <= cfg_data;
				REG_RADIUS:   sphere_radius_q <= cfg_data[N-2:0];
				default: ;
			endcase
		end
	end

	// valid bits alongside the data
	crsi_delay #(.W(1), .D(LAT)) u_vld (
		.clk(clk), .arst_n(arst_n), .en(en), .d(in_valid), .q(vld_out)
	);

	// coefficients a, h, c
	crsi_front #(.N(N)) u_front (
		.clk(clk), .en(en),
		.origin_x(origin_x), .origin_y(origin_y), .dir_x(dir_x), .dir_y(dir_y),
		.center_x(center_x_q), .center_y(center_y_q), .center_z(center_z_q),
		.radius(sphere_radius_q),
		.a(a3), .h(h3), .c(c3)
	);

	// h*h and a*c
	crsi_mul #(.WA(WC), .WB(WC)) u_mul_hh (
		.clk(clk), .en(en), .a(WC'(h3)), .b(WC'(h3)), .p(hh_m)
	);

	crsi_mul #(.WA(WC), .WB(WC)) u_mul_ac (
		.clk(clk), .en(en), .a($signed(WC'(a3))), .b(c3), .p(ac_m)
	);

	crsi_delay #(.W(WA + WH), .D(NS)) u_dly_mul (
		.clk(clk), .arst_n(arst_n), .en(en), .d({a3, h3}), .q({a_m, h_m})
	);

	// discriminant stage
	assign disc_c = hh_m - ac_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s4 <= 1'b0;
		end else if (en) begin
			hit_s4 <= (a_m != '0) && !disc_c[WD-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			disc_s4 <= ((a_m != '0) && !disc_c[WD-1]) ? disc_c : '0;
			a_s4    <= a_m;
			h_s4    <= h_m;
		end
	end

	// square root of the discriminant
	crsi_sqrt #(.WI(WD)) u_sqrt (
		.clk(clk), .en(en), .rad(disc_s4), .root(root)
	);

	crsi_delay #(.W(WA + WH + 1), .D(RB)) u_dly_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({a_s4, h_s4, hit_s4}), .q({a_r, h_r, hit_r})
	);

	// numerator -h - root in Q.32, scaled to Q.48, split into sign and magnitude
	assign num_c = -(WNUM'(h_r)) - $signed(WNUM'(root));
	assign shf_c = WS'(num_c) <<< FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s5 <= num_c[WNUM-1] ? WS'(-shf_c) : WS'(shf_c);
			neg_s5 <= num_c[WNUM-1];
			hit_s5 <= hit_r;
			a_s5   <= a_r;
		end
	end

	// magnitude divided by a
	crsi_div #(.WN(WS), .WDV(WA), .QB(QB)) u_div (
		.clk(clk), .en(en), .num(mag_s5), .den(a_s5),
		.quo(quo), .rem_nz(rem_nz), .ovf(ovf)
	);

	crsi_delay #(.W(2), .D(QB + 1)) u_dly_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({neg_s5, hit_s5}), .q({neg_d, hit_d})
	);

	assign a_dv = a_s5;

	// floor rounding for negative quotients, then saturation
	always_comb begin
		qm_c = (N+2)'(quo) + (N+2)'(neg_d && rem_nz);
		if (neg_d) begin
			if (ovf || (qm_c > NEG_LIM)) val_c = MIN_VAL;
			else                         val_c = N'(-qm_c);
		end else begin
			if (ovf || (qm_c > POS_LIM)) val_c = MAX_VAL;
			else                         val_c = qm_c[N-1:0];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s6  <= hit_d;
			dist_s6 <= hit_d ? val_c : '0;
		end
	end

	assign out_valid = vld_out;
	assign hit       = hit_s6;
	assign distance  = dist_s6;

`ifndef SYNTHESIS
	// a miss always reports zero distance
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> distance == '0)
		else $error("miss with nonzero distance");

	// a held output freezes the discriminant and numerator stages
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hit_s4) && $stable(disc_s4) && $stable(a_dv))
		else $error("pipeline moved while output held");

	// a zero direction never produces a hit at the discriminant stage
	assert property (@(posedge clk) disable iff (!arst_n)
		en && (a_m == '0) |=> !hit_s4)
		else $error("hit with zero direction");
`endif

endmodule
